/* hw/rtl/fsq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsq_pkg
// types and constants for the gf(2^255-19) squaring pipeline
// ----------------------------------------------------------------------------
package fsq_pkg;

    localparam int NUM_LIMBS = 10;
    localparam int COL_W     = 64;
    localparam logic [4:0] FOLD = 5'd19;

    typedef struct packed {
        logic [27:0] in_limb0;
        logic [26:0] in_limb1;
        logic [27:0] in_limb2;
        logic [26:0] in_limb3;
        logic [27:0] in_limb4;
        logic [26:0] in_limb5;
        logic [27:0] in_limb6;
        logic [26:0] in_limb7;
        logic [27:0] in_limb8;
        logic [26:0] in_limb9;
    } t_in_item;

    typedef struct packed {
        logic [25:0] out_limb0;
        logic [24:0] out_limb1;
        logic [26:0] out_limb2;
        logic [24:0] out_limb3;
        logic [25:0] out_limb4;
        logic [24:0] out_limb5;
        logic [25:0] out_limb6;
        logic [24:0] out_limb7;
        logic [25:0] out_limb8;
        logic [24:0] out_limb9;
    } t_out_item;

    typedef logic [COL_W-1:0] t_col;

endpackage
`default_nettype wire

/* hw/rtl/field_square_mod_p25519.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// field_square_mod_p25519
// squaring in gf(2^255-19), ten limbs of radix 2^25.5, pipelined
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  input   | in        | i_in_valid, o_in_stall, i_in_data
//  result  | out       | o_out_valid, i_out_stall, o_out_data
//
//  one item per cycle while the result register is free or taken.
//  stage 1: 55 limb products (28x28 bit), one multiplier each.
//  stage 2: scaling by 2/4/19 and column sums; stage 3: carry chain columns
//  0-4; stage 4: columns 5-9 and top carry; stage 5: fold into limbs 0..2.
//  the pipeline advances whenever the output register is free or taken.
//  reset clears all valid bits.
module field_square_mod_p25519 (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  fsq_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output fsq_pkg::t_out_item  o_out_data
);

    localparam int NP = 55;

    logic [4:0] r_vld;
    logic       w_adv;

    logic [27:0] w_a [10];
    logic [55:0] r_prod [NP];
    fsq_pkg::t_col r_col [10];
    fsq_pkg::t_col n_col [10];
    logic [25:0] r_lo [5];
    fsq_pkg::t_col r_t4;
    fsq_pkg::t_col r_col3 [5:9];
    fsq_pkg::t_col r_t9;
    logic [25:0] r_lo4 [10];
    fsq_pkg::t_out_item r_out;

    // stall only when the result register holds an untaken item
    assign w_adv      = !(r_vld[4] && i_out_stall);
    assign o_in_stall = !w_adv;

    assign w_a[0] = i_in_data.in_limb0;
    assign w_a[1] = {1'b0, i_in_data.in_limb1};
    assign w_a[2] = i_in_data.in_limb2;
    assign w_a[3] = {1'b0, i_in_data.in_limb3};
    assign w_a[4] = i_in_data.in_limb4;
    assign w_a[5] = {1'b0, i_in_data.in_limb5};
    assign w_a[6] = i_in_data.in_limb6;
    assign w_a[7] = {1'b0, i_in_data.in_limb7};
    assign w_a[8] = i_in_data.in_limb8;
    assign w_a[9] = {1'b0, i_in_data.in_limb9};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[3:0], i_in_valid};
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 10; i++) begin
                for (int j = i; j < 10; j++) begin
                    r_prod[i*10 - (i*(i-1))/2 + (j-i)] <= w_a[i] * w_a[j];
                end
            end
        end
    end

    // stage 2: scale and accumulate columns
    always_comb begin
        fsq_pkg::t_col p;
        for (int k = 0; k < 10; k++) begin
            n_col[k] = '0;
        end
        for (int i = 0; i < 10; i++) begin
            for (int j = i; j < 10; j++) begin
                p = {8'd0, r_prod[i*10 - (i*(i-1))/2 + (j-i)]};
                if (i != j) begin
                    p = p << 1;
                end
                if ((i % 2 == 1) && (j % 2 == 1)) begin
                    p = p << 1;
                end
                if (i + j >= 10) begin
                    p = (p << 4) + (p << 1) + p;
                    n_col[i+j-10] = n_col[i+j-10] + p;
                end else begin
                    n_col[i+j] = n_col[i+j] + p;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_col <= n_col;
        end
    end

    // stage 3: carry chain, columns 0..4
    always_ff @(posedge i_clk) begin
        fsq_pkg::t_col t;
        if (w_adv) begin
            t = r_col[0];
            r_lo[0] <= t[25:0];
            for (int i = 1; i < 5; i++) begin
                t = ((i % 2 == 1) ? (t >> 26) : (t >> 25)) + r_col[i];
                r_lo[i] <= t[25:0];
            end
            r_t4 <= t;
            for (int i = 5; i < 10; i++) begin
                r_col3[i] <= r_col[i];
            end
        end
    end

    // stage 4: carry chain, columns 5..9
    always_ff @(posedge i_clk) begin
        fsq_pkg::t_col t;
        if (w_adv) begin
            t = r_t4;
            for (int i = 0; i < 5; i++) begin
                r_lo4[i] <= r_lo[i];
            end
            for (int i = 5; i < 10; i++) begin
                t = ((i % 2 == 1) ? (t >> 26) : (t >> 25)) + r_col3[i];
                r_lo4[i] <= t[25:0];
            end
            r_t9 <= t;
        end
    end

    // stage 5: fold top carry times 19 into limbs 0..2
    always_ff @(posedge i_clk) begin
        logic [38:0] top;
        logic [31:0] x;
        logic [31:0] y;
        if (w_adv) begin
            top = r_t9[63:25];
            x = 32'(r_lo4[0]) + 32'(top * 39'(fsq_pkg::FOLD));
            y = 32'(x[31:26]) + 32'(r_lo4[1][24:0]);
            r_out.out_limb0 <= x[25:0];
            r_out.out_limb1 <= y[24:0];
            r_out.out_limb2 <= 27'(r_lo4[2]) + 27'(y[25]);
            r_out.out_limb3 <= r_lo4[3][24:0];
            r_out.out_limb4 <= r_lo4[4];
            r_out.out_limb5 <= r_lo4[5][24:0];
            r_out.out_limb6 <= r_lo4[6];
            r_out.out_limb7 <= r_lo4[7][24:0];
            r_out.out_limb8 <= r_lo4[8];
            r_out.out_limb9 <= r_lo4[9][24:0];
        end
    end

    assign o_out_valid = r_vld[4];
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

/* hw/rtl/fsq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsq_checker
// port-level checks for the squaring pipeline
// ----------------------------------------------------------------------------
module fsq_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input fsq_pkg::t_in_item   i_in_data,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input fsq_pkg::t_out_item  o_out_data
);

    // input stalls only while a result waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stall without a waiting result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // an input transfer shows up as a result when the pipeline is never stalled in between
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !o_in_stall ##1 !o_in_stall
            ##1 !o_in_stall ##1 !o_in_stall |=> o_out_valid)
        else $error("result missing after transfer");

    // reduced limb 2 stays in range
    a_limb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.out_limb2 <= 27'd67108864))
        else $error("limb 2 out of range");

endmodule

bind field_square_mod_p25519 fsq_checker u_fsq_checker (.*);
`default_nettype wire

/* sim/field_square_mod_p25519_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// field_square_mod_p25519_tb
// squares random and corner-case field elements and checks every result
// limb against a software squaring model, under varying idle and stall load
// ----------------------------------------------------------------------------
module field_square_mod_p25519_tb;

    localparam int WATCHDOG = 20000;
    localparam logic [27:0] EVEN_LOOSE = 28'd221459250;
    localparam logic [26:0] ODD_LOOSE  = 27'd110729625;
    localparam logic [63:0] MASK26 = 64'h3ffffff;
    localparam logic [63:0] MASK25 = 64'h1ffffff;

    class square_scoreboard;
        fsq_pkg::t_out_item pending_squares[$];
        int        n_errors;
        int        n_checked;

        function fsq_pkg::t_out_item square_limbs(fsq_pkg::t_in_item item);
            logic [63:0] a [10];
            logic [63:0] col [10];
            logic [63:0] r [10];
            logic [63:0] p, acc, top;
            logic [31:0] x, y;
            fsq_pkg::t_out_item res;
            a[0] = 64'(item.in_limb0); a[1] = 64'(item.in_limb1);
            a[2] = 64'(item.in_limb2); a[3] = 64'(item.in_limb3);
            a[4] = 64'(item.in_limb4); a[5] = 64'(item.in_limb5);
            a[6] = 64'(item.in_limb6); a[7] = 64'(item.in_limb7);
            a[8] = 64'(item.in_limb8); a[9] = 64'(item.in_limb9);
            for (int i = 0; i < 10; i++) col[i] = '0;
            for (int i = 0; i < 10; i++) begin
                for (int j = i; j < 10; j++) begin
                    p = a[i] * a[j];
                    if (i != j) p = p * 2;
                    if ((i % 2 == 1) && (j % 2 == 1)) p = p * 2;
                    if (i + j >= 10) begin
                        p = p * 19;
                        col[i + j - 10] += p;
                    end else begin
                        col[i + j] += p;
                    end
                end
            end
            acc = col[0];
            r[0] = acc & MASK26;
            for (int i = 1; i < 10; i++) begin
                acc = (acc >> ((i % 2 == 1) ? 26 : 25)) + col[i];
                r[i] = acc & ((i % 2 == 1) ? MASK25 : MASK26);
            end
            top = acc >> 25;
            x = 32'(r[0] + top * 19);
            y = (x >> 26) + 32'(r[1]);
            res.out_limb0 = x[25:0];
            res.out_limb1 = y[24:0];
            res.out_limb2 = 27'(r[2] + 64'(y[25]));
            res.out_limb3 = r[3][24:0];
            res.out_limb4 = r[4][25:0];
            res.out_limb5 = r[5][24:0];
            res.out_limb6 = r[6][25:0];
            res.out_limb7 = r[7][24:0];
            res.out_limb8 = r[8][25:0];
            res.out_limb9 = r[9][24:0];
            return res;
        endfunction

        function void note_input(fsq_pkg::t_in_item item);
            pending_squares.push_back(square_limbs(item));
        endfunction

        function void check_result(fsq_pkg::t_out_item got);
            fsq_pkg::t_out_item exp_sq;
            if (pending_squares.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                n_errors++;
                return;
            end
            exp_sq = pending_squares.pop_front();
            n_checked++;
            if (got.out_limb0 != exp_sq.out_limb0) report(0, exp_sq.out_limb0, got.out_limb0);
            if (got.out_limb1 != exp_sq.out_limb1) report(1, exp_sq.out_limb1, got.out_limb1);
            if (got.out_limb2 != exp_sq.out_limb2) report(2, exp_sq.out_limb2, got.out_limb2);
            if (got.out_limb3 != exp_sq.out_limb3) report(3, exp_sq.out_limb3, got.out_limb3);
            if (got.out_limb4 != exp_sq.out_limb4) report(4, exp_sq.out_limb4, got.out_limb4);
            if (got.out_limb5 != exp_sq.out_limb5) report(5, exp_sq.out_limb5, got.out_limb5);
            if (got.out_limb6 != exp_sq.out_limb6) report(6, exp_sq.out_limb6, got.out_limb6);
            if (got.out_limb7 != exp_sq.out_limb7) report(7, exp_sq.out_limb7, got.out_limb7);
            if (got.out_limb8 != exp_sq.out_limb8) report(8, exp_sq.out_limb8, got.out_limb8);
            if (got.out_limb9 != exp_sq.out_limb9) report(9, exp_sq.out_limb9, got.out_limb9);
        endfunction

        function void report(int idx, logic [26:0] exp_v, logic [26:0] act_v);
            $display("%0t: out_limb%0d expected %h actual %h", $time, idx, exp_v, act_v);
            n_errors++;
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    fsq_pkg::t_in_item  i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    fsq_pkg::t_out_item o_out_data;

    square_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_count     = 0;
    bit timed_out      = 1'b0;
    int n_sent         = 0;

    always #1 i_clk = ~i_clk;

    field_square_mod_p25519 i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // result side: sample transfers, randomize stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_count <= 0;
            end else begin
                idle_count <= idle_count + 1;
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (idle_count >= WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [27:0] rand_even();
        case ($urandom_range(7))
            0: return 28'd0;
            1: return EVEN_LOOSE;
            2: return 28'(MASK26);
            default: return 28'($urandom_range(EVEN_LOOSE));
        endcase
    endfunction

    function automatic logic [26:0] rand_odd();
        case ($urandom_range(7))
            0: return 27'd0;
            1: return ODD_LOOSE;
            2: return 27'(MASK25);
            default: return 27'($urandom_range(ODD_LOOSE));
        endcase
    endfunction

    // drive one element; holds until the transfer happens
    task automatic send_square(fsq_pkg::t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(item);
        n_sent++;
    endtask

    task automatic send_uniform(logic [27:0] ev, logic [26:0] od);
        fsq_pkg::t_in_item item;
        item = '{ev, od, ev, od, ev, od, ev, od, ev, od};
        send_square(item);
    endtask

    task automatic send_random();
        fsq_pkg::t_in_item item;
        if ($urandom_range(19) == 0) begin
            // outside the loose bounds: full-width bit patterns, wrap behavior
            item = $bits(fsq_pkg::t_in_item)'({$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom});
        end else begin
            item = '{rand_even(), rand_odd(), rand_even(), rand_odd(), rand_even(),
                     rand_odd(), rand_even(), rand_odd(), rand_even(), rand_odd()};
        end
        send_square(item);
    endtask

    initial begin
        fsq_pkg::t_in_item item;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_uniform('0, '0);
        send_uniform(EVEN_LOOSE, ODD_LOOSE);
        send_uniform(28'(MASK26), 27'(MASK25));
        send_uniform(28'hfffffff, 27'h7ffffff);
        send_uniform(28'd1, 27'd0);
        send_uniform(28'(MASK26) - 28'd18, 27'(MASK25));
        for (int k = 0; k < 10; k++) begin
            item = '0;
            item[k * 27 + 26 -: 27] = '1;
            send_square(item);
        end
        item = '0;
        item.in_limb9 = ODD_LOOSE;
        send_square(item);
        item.in_limb0 = EVEN_LOOSE;
        send_square(item);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int n = 0; n < 325; n++) send_random();
        end
        i_in_valid <= 1'b0;
        recv_stall_pct = 30;

        while (sb.pending_squares.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("squared %0d elements (corners, out-of-bound patterns, random) and checked %0d",
                 n_sent, sb.n_checked);
        $display("load phases: free-running, sparse input, heavy back-pressure, light both");
        if (sb.n_errors == 0 && sb.pending_squares.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
